@@ src/segi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package segi_pkg;

	localparam logic [1:0] ST_NONE  = 2'd0;
	localparam logic [1:0] ST_HIT   = 2'd1;
	localparam logic [1:0] ST_TOUCH = 2'd2;

	localparam logic [1:0] REG_SIDE     = 2'd0;
	localparam logic [1:0] REG_TOUCH    = 2'd1;
	localparam logic [1:0] REG_PARALLEL = 2'd2;

	localparam int COORD_W = 16;
	localparam int CFG_W   = 32;
	// |numerator| below 2^50, |determinant| below 2^34
	localparam int NUM_W   = 51;
	localparam int DEN_W   = 35;
	localparam int ACC_W   = NUM_W + 1;
	localparam int QUO_W   = 16;
	// operand stage + one stage per quotient bit + saturation stage
	localparam int DIV_LAT = QUO_W + 2;

	localparam logic signed [QUO_W-1:0] SAT_POS = 16'sh7FFF;
	localparam logic signed [QUO_W-1:0] SAT_NEG = 16'sh8000;

endpackage
`default_nettype wire

@@ src/segi_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface segi_req_if;
	logic valid;
	logic ready;
	logic signed [15:0] ax_start;
	logic signed [15:0] ay_start;
	logic signed [15:0] ax_end;
	logic signed [15:0] ay_end;
	logic signed [15:0] bx_start;
	logic signed [15:0] by_start;
	logic signed [15:0] bx_end;
	logic signed [15:0] by_end;

	modport source(output valid, ax_start, ay_start, ax_end, ay_end,
		bx_start, by_start, bx_end, by_end, input ready);
	modport sink(input valid, ax_start, ay_start, ax_end, ay_end,
		bx_start, by_start, bx_end, by_end, output ready);
endinterface

interface segi_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic signed [15:0] hit_x;
	logic signed [15:0] hit_y;

	modport source(output valid, status, hit_x, hit_y, input ready);
	modport sink(input valid, status, hit_x, hit_y, output ready);
endinterface
`default_nettype wire

@@ src/segi_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module segi_div import segi_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [NUM_W-1:0]        num,
	input  wire logic [DEN_W-1:0]        den,
	input  wire logic                    neg,
	output logic signed [QUO_W-1:0]      quo
);

	logic [NUM_W-1:0] rem_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic [DEN_W-1:0] den_s [0:QUO_W];
	logic             neg_s [0:QUO_W];
	logic             ovf_s [0:QUO_W];
	logic signed [QUO_W-1:0] res_q;
	logic [QUO_W:0]   qm;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
			// quotient of 2^16 or more saturates either way
			ovf_s[0] <= ACC_W'(num) >= (ACC_W'(den) << QUO_W);
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [ACC_W-1:0] sh;
		logic [ACC_W-1:0] diff;
		logic             take;
		assign sh   = ACC_W'(den_s[k]) << (QUO_W - 1 - k);
		assign diff = ACC_W'(rem_s[k]) - sh;
		assign take = ACC_W'(rem_s[k]) >= sh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? diff[NUM_W-1:0] : rem_s[k];
				quo_s[k+1] <= quo_s[k] | (QUO_W'(take) << (QUO_W - 1 - k));
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign qm = ovf_s[QUO_W] ? {1'b1, QUO_W'(0)} : {1'b0, quo_s[QUO_W]};

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[QUO_W])
				res_q <= (qm >= {2'b01, (QUO_W-1)'(0)}) ? SAT_NEG : -$signed(qm[QUO_W-1:0]);
			else
				res_q <= (qm > {2'b00, {(QUO_W-1){1'b1}}}) ? SAT_POS : $signed(qm[QUO_W-1:0]);
		end
	end

	assign quo = res_q;

endmodule
`default_nettype wire

@@ src/segment_intersection.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Classifies a pair of Q8.8 segments as no hit, crossing (with the crossing point) or
// overlapping/touching, using three thresholds written through the cfg port. Fully
// pipelined: one pair per clock. Most of the pipeline depth comes from the two
// restoring dividers (one quotient bit per stage) that produce the crossing point.
// When the result is held the whole pipe stalls.
module segment_intersection import segi_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	segi_req_if.sink              req,
	segi_rsp_if.source            rsp
);

	localparam int LAST = 5 + DIV_LAT;

	logic [CFG_W-1:0] side_limit_q, touch_limit_q, parallel_limit_q;
	logic en;
	logic vld_s [1:LAST];
	logic [1:0] stat_s [6:LAST];

	// stage 1
	logic signed [15:0] x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;
	logic signed [16:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [31:0] p1_s1, p2_s1, p3_s1, p4_s1;
	// stage 2
	logic signed [16:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [32:0] c1_s2, c2_s2;
	logic signed [32:0] ma3_s2, mb3_s2, ma4_s2, mb4_s2, ma1_s2, mb1_s2, ma2_s2, mb2_s2;
	logic signed [34:0] d1_s2, d2_s2;
	// stage 3
	logic signed [34:0] r1_s3, r2_s3, r3_s3, r4_s3, det_s3;
	logic signed [NUM_W-1:0] n1_s3, n2_s3, n3_s3, n4_s3;
	// stage 4
	logic [34:0] rm1_s4, rm2_s4, rm3_s4, rm4_s4;
	logic pos12_s4, pos34_s4, dneg_s4;
	logic [DEN_W-1:0] detm_s4;
	logic signed [NUM_W-1:0] nx_s4, ny_s4;
	// stage 5
	logic [69:0] pr12_s5, pr34_s5;
	logic pos12_s5, pos34_s5, negx_s5, negy_s5;
	logic [DEN_W-1:0] detm_s5;
	logic [NUM_W-1:0] nxm_s5, nym_s5;

	logic above34, above12, below, parallel;
	logic [1:0] stat_d;
	logic signed [QUO_W-1:0] qx, qy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_limit_q     <= 32'd4294967;
			touch_limit_q    <= 32'd429;
			parallel_limit_q <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIDE:     side_limit_q     <= cfg_data;
				REG_TOUCH:    touch_limit_q    <= cfg_data;
				REG_PARALLEL: parallel_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en        = !vld_s[LAST] || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= req.valid;
			for (int i = 2; i <= LAST; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= req.ax_start;  y1_s1 <= req.ay_start;
			x2_s1 <= req.ax_end;    y2_s1 <= req.ay_end;
			x3_s1 <= req.bx_start;  y3_s1 <= req.by_start;
			x4_s1 <= req.bx_end;    y4_s1 <= req.by_end;
			a1_s1 <= 17'(req.ay_end) - 17'(req.ay_start);
			b1_s1 <= 17'(req.ax_start) - 17'(req.ax_end);
			a2_s1 <= 17'(req.by_end) - 17'(req.by_start);
			b2_s1 <= 17'(req.bx_start) - 17'(req.bx_end);
			p1_s1 <= 32'(req.ax_end) * 32'(req.ay_start);
			p2_s1 <= 32'(req.ax_start) * 32'(req.ay_end);
			p3_s1 <= 32'(req.bx_end) * 32'(req.by_start);
			p4_s1 <= 32'(req.bx_start) * 32'(req.by_end);

			a1_s2 <= a1_s1;  b1_s2 <= b1_s1;  a2_s2 <= a2_s1;  b2_s2 <= b2_s1;
			c1_s2 <= 33'(p1_s1) - 33'(p2_s1);
			c2_s2 <= 33'(p3_s1) - 33'(p4_s1);
			ma3_s2 <= 33'(a1_s1) * 33'(x3_s1);
			mb3_s2 <= 33'(b1_s1) * 33'(y3_s1);
			ma4_s2 <= 33'(a1_s1) * 33'(x4_s1);
			mb4_s2 <= 33'(b1_s1) * 33'(y4_s1);
			ma1_s2 <= 33'(a2_s1) * 33'(x1_s1);
			mb1_s2 <= 33'(b2_s1) * 33'(y1_s1);
			ma2_s2 <= 33'(a2_s1) * 33'(x2_s1);
			mb2_s2 <= 33'(b2_s1) * 33'(y2_s1);
			d1_s2  <= 35'(a1_s1) * 35'(b2_s1);
			d2_s2  <= 35'(a2_s1) * 35'(b1_s1);

			r3_s3  <= 35'(ma3_s2) + 35'(mb3_s2) + 35'(c1_s2);
			r4_s3  <= 35'(ma4_s2) + 35'(mb4_s2) + 35'(c1_s2);
			r1_s3  <= 35'(ma1_s2) + 35'(mb1_s2) + 35'(c2_s2);
			r2_s3  <= 35'(ma2_s2) + 35'(mb2_s2) + 35'(c2_s2);
			det_s3 <= d1_s2 - d2_s2;
			n1_s3  <= NUM_W'(b1_s2) * NUM_W'(c2_s2);
			n2_s3  <= NUM_W'(b2_s2) * NUM_W'(c1_s2);
			n3_s3  <= NUM_W'(a2_s2) * NUM_W'(c1_s2);
			n4_s3  <= NUM_W'(a1_s2) * NUM_W'(c2_s2);

			rm1_s4   <= r1_s3[34] ? 35'(-r1_s3) : 35'(r1_s3);
			rm2_s4   <= r2_s3[34] ? 35'(-r2_s3) : 35'(r2_s3);
			rm3_s4   <= r3_s3[34] ? 35'(-r3_s3) : 35'(r3_s3);
			rm4_s4   <= r4_s3[34] ? 35'(-r4_s3) : 35'(r4_s3);
			pos12_s4 <= (r1_s3 > 0 && r2_s3 > 0) || (r1_s3 < 0 && r2_s3 < 0);
			pos34_s4 <= (r3_s3 > 0 && r4_s3 > 0) || (r3_s3 < 0 && r4_s3 < 0);
			detm_s4  <= det_s3[34] ? DEN_W'(-det_s3) : DEN_W'(det_s3);
			dneg_s4  <= det_s3[34];
			nx_s4    <= n1_s3 - n2_s3;
			ny_s4    <= n3_s3 - n4_s3;

			pr12_s5  <= 70'(rm1_s4) * 70'(rm2_s4);
			pr34_s5  <= 70'(rm3_s4) * 70'(rm4_s4);
			pos12_s5 <= pos12_s4;
			pos34_s5 <= pos34_s4;
			detm_s5  <= detm_s4;
			nxm_s5   <= nx_s4[NUM_W-1] ? NUM_W'(-nx_s4) : NUM_W'(nx_s4);
			nym_s5   <= ny_s4[NUM_W-1] ? NUM_W'(-ny_s4) : NUM_W'(ny_s4);
			negx_s5  <= nx_s4[NUM_W-1] ^ dneg_s4;
			negy_s5  <= ny_s4[NUM_W-1] ^ dneg_s4;

			stat_s[6] <= stat_d;
			for (int i = 7; i <= LAST; i++) stat_s[i] <= stat_s[i-1];
		end
	end

	// test order: first-line side, second-line side, overlap, parallel
	assign above34  = pos34_s5 && (pr34_s5 > 70'(side_limit_q));
	assign above12  = pos12_s5 && (pr12_s5 > 70'(touch_limit_q));
	assign below    = (pr12_s5 < 70'(touch_limit_q)) && (pr34_s5 < 70'(touch_limit_q));
	assign parallel = (detm_s5 == '0) || (detm_s5 < DEN_W'(parallel_limit_q));

	always_comb begin
		if (above34 || above12) stat_d = ST_NONE;
		else if (below)         stat_d = ST_TOUCH;
		else if (parallel)      stat_d = ST_NONE;
		else                    stat_d = ST_HIT;
	end

	segi_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (nxm_s5),
		.den (detm_s5),
		.neg (negx_s5),
		.quo (qx)
	);

	segi_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (nym_s5),
		.den (detm_s5),
		.neg (negy_s5),
		.quo (qy)
	);

	assign rsp.valid  = vld_s[LAST];
	assign rsp.status = stat_s[LAST];
	assign rsp.hit_x  = (stat_s[LAST] == ST_HIT) ? qx : '0;
	assign rsp.hit_y  = (stat_s[LAST] == ST_HIT) ? qy : '0;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp.valid |-> req.ready)
		else $error("request stalled with empty output stage");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status == ST_NONE || rsp.status == ST_HIT ||
			rsp.status == ST_TOUCH))
		else $error("illegal status code");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[LAST] && !rsp.ready) |=> (vld_s[LAST] && $stable(stat_s[LAST])))
		else $error("held result changed in last stage");

endmodule
`default_nettype wire
